// ----- design/mnso_pkg.sv -----
// Package for the note-driven sine oscillator: field widths, operation codes,
// default parameters and the elaboration-time functions that build the tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mnso_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned NOTE_W   = 7;
	localparam int unsigned AMP_W    = 15;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned NOTES    = 1 << NOTE_W;

	localparam int unsigned PHASE_BITS_DEF      = 32;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;
	localparam int unsigned SAMPLE_RATE_HZ_DEF  = 48000;

	localparam logic [AMP_W-1:0] AMP_RESET = 15'd2000;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned HALF_Q30 = 64'd536870912;

	localparam longint unsigned SEMITONE_Q30 [12] = '{
		64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
		64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
		64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
	};

	// Shift-and-subtract quotient, used only while the tables are built.
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series of sin(x) in Q30 for x in the first quadrant.
	function automatic longint unsigned sin_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 10; n++) begin
			term = (term * x2) >> 30;
			term = udiv64(term, 64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// Q1.15 sine table entry k of a table with 2^tb entries.
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k,
		input int unsigned tb);
		longint unsigned quarter;
		longint unsigned q;
		longint unsigned r;
		longint unsigned x;
		longint unsigned v;
		quarter = 64'd1 << (tb - 2);
		q = 64'(k) >> (tb - 2);
		r = 64'(k) & (quarter - 64'd1);
		if (q[0]) begin
			r = quarter - r;
		end
		x = (PI_Q30 * r) >> (tb - 1);
		v = (sin_q30(x) * 64'd32767 + HALF_Q30) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		if (q >= 64'd2) begin
			return -SAMPLE_W'(v);
		end
		return SAMPLE_W'(v);
	endfunction

	// Phase step for a note, rounded half up and wrapped to pb bits.
	function automatic longint unsigned note_step(input int unsigned note,
		input int unsigned pb, input int unsigned sr);
		int d;
		int oct;
		int semi;
		int e;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		if (note == 0) begin
			return 64'd0;
		end
		d = int'(note) + 3;
		oct = d / 12 - 6;
		semi = d % 12;
		e = int'(pb) + oct - 30;
		num = 64'd440 * SEMITONE_Q30[semi];
		if (e >= 0) begin
			q = udiv64((num << e) + (64'(sr) >> 1), 64'(sr));
		end else begin
			den = 64'(sr) << (-e);
			q = udiv64(num + (den >> 1), den);
		end
		return q & ((64'd1 << pb) - 64'd1);
	endfunction

endpackage

`default_nettype wire

// ----- design/midi_note_sine_oscillator.sv -----
// Top level of the note-driven sine oscillator: stream ports, amplitude register
// and stage control. Depends on mnso_pkg, mnso_phase, mnso_sine_rom, mnso_scale.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the slave side is a start, stop or tick command. Only a tick
// yields a sample on the master side, which leaves the output register when the
// output is not stalled. One command is taken per cycle unless a stall has filled
// the stages. The three stages are the phase index register, the registered sine
// table read and the output register after the amplitude multiply. A stage moves
// on whenever the stage after it is empty or moving, so bubbles fill while a
// sample waits. The first tick after a start gives sine of zero. Amplitude may be
// written at any time the block holds no pending tick.
module midi_note_sine_oscillator import mnso_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int unsigned SAMPLE_RATE_HZ  = SAMPLE_RATE_HZ_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [6:0] note, [7] zero
	input  wire  [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [14:0] cfg_data   // [14:0] amplitude
);

	logic                       en1;
	logic                       en2;
	logic                       en3;
	logic                       in_accept;
	logic                       vld_s1;
	logic [SINE_TABLE_BITS-1:0] idx_s1;
	logic                       vld_s2;
	logic signed [SAMPLE_W-1:0] sine_s2;
	logic [AMP_W-1:0]           amplitude_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			amplitude_q <= cfg_data;
		end
	end

	assign en3       = !m_tvalid || m_tready;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign s_tready  = en1;
	assign in_accept = s_tvalid && s_tready;

	mnso_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (en1),
		.in_accept (in_accept),
		.in_op     (s_tuser),
		.in_note   (s_tdata[NOTE_W-1:0]),
		.vld_s1    (vld_s1),
		.idx_s1    (idx_s1)
	);

	mnso_sine_rom #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sine_rom (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (en2),
		.vld_s1  (vld_s1),
		.idx_s1  (idx_s1),
		.vld_s2  (vld_s2),
		.sine_s2 (sine_s2)
	);

	mnso_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (en3),
		.vld_s2    (vld_s2),
		.sine_s2   (sine_s2),
		.amplitude (amplitude_q),
		.out_vld_q (m_tvalid),
		.sample_q  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- design/mnso_phase.sv -----
// Phase accumulator with the note-to-step table; registers the sine index of
// each accepted tick. Depends on mnso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnso_phase import mnso_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
	parameter int unsigned SAMPLE_RATE_HZ  = SAMPLE_RATE_HZ_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        adv,
	input  wire                        in_accept,
	input  wire  [OP_W-1:0]            in_op,
	input  wire  [NOTE_W-1:0]          in_note,
	output logic                       vld_s1,
	output logic [SINE_TABLE_BITS-1:0] idx_s1
);

	logic [PHASE_BITS-1:0] step_rom [NOTES];
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic                  tick;

	for (genvar n = 0; n < NOTES; n++) begin : g_step
		localparam logic [PHASE_BITS-1:0] STEP =
			PHASE_BITS'(note_step(n, PHASE_BITS, SAMPLE_RATE_HZ));
		assign step_rom[n] = STEP;
	end

	assign tick = in_accept && (in_op == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= tick;
			end
			if (in_accept) begin
				case (in_op)
					OP_START: begin
						phase_q <= '0;
						step_q  <= step_rom[in_note];
					end
					OP_STOP: begin
						phase_q <= '0;
						step_q  <= '0;
					end
					OP_TICK: begin
						phase_q <= phase_q + step_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			idx_s1 <= phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
		end
	end

`ifndef ASSERT_OFF
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_op == OP_STOP |=> phase_q == '0 && step_q == '0)
		else $error("stop did not clear phase and step");
	a_note_zero_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_op == OP_START && in_note == '0 |=> step_q == '0 && phase_q == '0)
		else $error("note zero did not give a silent step");
	a_tick_adds: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> phase_q == PHASE_BITS'($past(phase_q) + $past(step_q)))
		else $error("tick did not advance the phase by the step");
`endif

endmodule

`default_nettype wire

// ----- design/mnso_sine_rom.sv -----
// Sine table of 2^SINE_TABLE_BITS Q1.15 entries with a registered read port.
// Depends on mnso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnso_sine_rom import mnso_pkg::*; #(
	parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               adv,
	input  wire                               vld_s1,
	input  wire        [SINE_TABLE_BITS-1:0]  idx_s1,
	output logic                              vld_s2,
	output logic signed [SAMPLE_W-1:0]        sine_s2
);

	localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;

	logic signed [SAMPLE_W-1:0] rom [SINE_N];

	for (genvar k = 0; k < SINE_N; k++) begin : g_sine
		localparam logic signed [SAMPLE_W-1:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
		assign rom[k] = ENTRY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			sine_s2 <= rom[idx_s1];
		end
	end

endmodule

`default_nettype wire

// ----- design/mnso_scale.sv -----
// Scales the sine value by the amplitude, truncating toward zero, and holds
// the result in the output register. Depends on mnso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnso_scale import mnso_pkg::*; (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        adv,
	input  wire                        vld_s2,
	input  wire signed [SAMPLE_W-1:0]  sine_s2,
	input  wire        [AMP_W-1:0]     amplitude,
	output logic                       out_vld_q,
	output logic       [SAMPLE_W-1:0]  sample_q
);

	logic                      neg;
	logic [AMP_W-1:0]          mag;
	logic [2*AMP_W-1:0]        prod;
	logic [SAMPLE_W-1:0]       scaled;
	logic [SAMPLE_W-1:0]       abs_full;

	always_comb begin
		neg      = sine_s2[SAMPLE_W-1];
		abs_full = neg ? SAMPLE_W'(-sine_s2) : SAMPLE_W'(sine_s2);
		mag      = abs_full[AMP_W-1:0];
		prod     = amplitude * mag;
		scaled   = {1'b0, prod[2*AMP_W-1:AMP_W]};
		if (neg) begin
			scaled = -scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			sample_q <= scaled;
		end
	end

`ifndef ASSERT_OFF
	a_zero_in_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s2 && sine_s2 == '0 |=> out_vld_q && sample_q == '0)
		else $error("zero sine value gave a nonzero sample");
`endif

endmodule

`default_nettype wire
